[src/wmp_pkg.sv]
// ----------------------------------------------------------------------------
// wmp_pkg: shared types and constants of the weighted multimap picker
// Table geometry, field widths, controller state, command and status groups.
// ----------------------------------------------------------------------------
package wmp_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int KEY_BITS      = 64;
	localparam int MOVE_BITS     = 24;
	localparam int WEIGHT_BITS   = 16;
	localparam int RAND_BITS     = 31;

	localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
	localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);
	localparam int SUM_BITS      = WEIGHT_BITS + CNT_BITS;
	localparam int DIV_CNT_BITS  = $clog2(RAND_BITS + 1);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic [KEY_BITS-1:0]    key;
		logic [MOVE_BITS-1:0]   move;
		logic [WEIGHT_BITS-1:0] weight;
	} wmp_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_PICK,
		ST_FINISH
	} wmp_state_t;

	typedef struct packed {
		logic accept;
		logic sum_pass;
		logic scan_clear;
		logic div_start;
		logic div_step;
		logic pick_pass;
		logic load_out;
	} wmp_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic have_first;
		logic total_zero;
		logic div_done;
		logic out_free;
	} wmp_stat_t;

endpackage

[src/wmp_ctrl.sv]
// ----------------------------------------------------------------------------
// wmp_ctrl: sequencer of the weighted multimap picker
// Steps a lookup through sum pass, remainder and pick pass; an insert goes straight to the result.
// ----------------------------------------------------------------------------
module wmp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_op,
	output logic               in_ready,
	input  wmp_pkg::wmp_stat_t stat,
	output wmp_pkg::wmp_cmd_t  cmd
);
	import wmp_pkg::*;

	wmp_state_t state_q;
	wmp_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = (in_op == OP_LOOKUP) ? ST_SUM : ST_FINISH;
				end
			end
			ST_SUM: begin
				cmd.sum_pass = 1'b1;
				if (stat.scan_done) begin
					if (stat.have_first && !stat.total_zero) begin
						cmd.scan_clear = 1'b1;
						cmd.div_start  = 1'b1;
						state_d        = ST_DIV;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				cmd.pick_pass = 1'b1;
				if (stat.scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[src/wmp_datapath.sv]
// ----------------------------------------------------------------------------
// wmp_datapath: entry table, scan logic, remainder unit and result register
// Holds the entry memory and carries out the commands of the sequencer.
// ----------------------------------------------------------------------------
module wmp_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wmp_pkg::wmp_cmd_t               cmd,
	output wmp_pkg::wmp_stat_t              stat,
	input  logic                            operation,
	input  logic [wmp_pkg::KEY_BITS-1:0]    position_key,
	input  logic [wmp_pkg::MOVE_BITS-1:0]   move_word,
	input  logic [wmp_pkg::WEIGHT_BITS-1:0] move_weight,
	input  logic [wmp_pkg::RAND_BITS-1:0]   random_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	output logic [wmp_pkg::MOVE_BITS-1:0]   chosen_move,
	output logic                            table_full
);
	import wmp_pkg::*;

	// entry memory and its registered read port
	wmp_entry_t mem [TABLE_ENTRIES];
	wmp_entry_t rd_data_s1;

	// control state
	logic [CNT_BITS-1:0]     fill_q;
	logic [CNT_BITS-1:0]     scan_idx_q;
	logic                    rd_vld_s1;
	logic                    have_first_q;
	logic                    hit_q;
	logic                    op_q;
	logic                    full_q;
	logic [DIV_CNT_BITS-1:0] div_cnt_q;
	logic                    out_valid_q;

	// payload state
	logic [KEY_BITS-1:0]     key_q;
	logic [RAND_BITS-1:0]    dvd_q;
	logic [SUM_BITS-1:0]     total_q;
	logic [SUM_BITS-1:0]     rem_q;
	logic [SUM_BITS-1:0]     running_q;
	logic [MOVE_BITS-1:0]    chosen_q;
	logic                    found_out_q;
	logic [MOVE_BITS-1:0]    chosen_out_q;
	logic                    full_out_q;

	logic                    has_room;
	logic                    wr_en;
	logic                    scan_active;
	logic                    rd_en;
	logic                    match;
	logic [SUM_BITS-1:0]     weight_ext;
	logic [SUM_BITS-1:0]     running_next;
	logic [SUM_BITS:0]       div_trial;
	logic                    div_fits;
	logic [SUM_BITS-1:0]     rem_next;
	logic                    div_done;

	assign has_room    = (fill_q < CNT_BITS'(TABLE_ENTRIES));
	assign wr_en       = cmd.accept && (operation == OP_INSERT) && has_room;
	assign scan_active = cmd.sum_pass || cmd.pick_pass;
	assign rd_en       = scan_active && (scan_idx_q < fill_q);
	assign match       = rd_vld_s1 && (rd_data_s1.key == key_q);
	assign weight_ext  = SUM_BITS'(rd_data_s1.weight);
	assign running_next = running_q + weight_ext;
	assign div_done    = (div_cnt_q == DIV_CNT_BITS'(RAND_BITS));

	// restoring remainder step: one dividend bit per cycle
	assign div_trial = {rem_q, dvd_q[RAND_BITS-1]};
	assign div_fits  = (div_trial >= {1'b0, total_q});
	assign rem_next  = div_fits ? SUM_BITS'(div_trial - {1'b0, total_q})
	                            : div_trial[SUM_BITS-1:0];

	// write appended entries, read the scanned entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[IDX_BITS-1:0]] <= '{key: position_key, move: move_word,
			                               weight: move_weight};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[scan_idx_q[IDX_BITS-1:0]];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			scan_idx_q   <= '0;
			rd_vld_s1    <= 1'b0;
			have_first_q <= 1'b0;
			hit_q        <= 1'b0;
			op_q         <= OP_INSERT;
			full_q       <= 1'b0;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// latch the transaction and append on insert
			if (cmd.accept) begin
				op_q         <= operation;
				full_q       <= (operation == OP_INSERT) && !has_room;
				have_first_q <= 1'b0;
				hit_q        <= 1'b0;
				scan_idx_q   <= '0;
				rd_vld_s1    <= 1'b0;
				if (wr_en) begin
					fill_q <= fill_q + CNT_BITS'(1);
				end
			end else if (cmd.scan_clear) begin
				scan_idx_q <= '0;
				rd_vld_s1  <= 1'b0;
			end else if (scan_active) begin
				// advance the scan index
				rd_vld_s1 <= rd_en;
				if (rd_en) begin
					scan_idx_q <= scan_idx_q + CNT_BITS'(1);
				end
			end
			if (cmd.sum_pass && match) begin
				have_first_q <= 1'b1;
			end
			if (cmd.pick_pass && match && !hit_q && (rem_q < running_next)) begin
				hit_q <= 1'b1;
			end
			// step the remainder counter
			if (cmd.div_start) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step && !div_done) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_BITS'(1);
			end
			// hold the result until it is taken
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q    <= position_key;
			dvd_q    <= random_value;
			total_q  <= '0;
			chosen_q <= '0;
		end
		// sum the matching weights, keep the first matching move
		if (cmd.sum_pass && match) begin
			total_q <= total_q + weight_ext;
			if (!have_first_q) begin
				chosen_q <= rd_data_s1.move;
			end
		end
		if (cmd.div_start) begin
			rem_q     <= '0;
			running_q <= '0;
		end else if (cmd.div_step && !div_done) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[RAND_BITS-2:0], 1'b0};
		end
		// walk the cumulative weights, take the first one past the draw
		if (cmd.pick_pass && match && !hit_q) begin
			running_q <= running_next;
			if (rem_q < running_next) begin
				chosen_q <= rd_data_s1.move;
			end
		end
		if (cmd.load_out) begin
			found_out_q  <= (op_q == OP_LOOKUP) && have_first_q;
			chosen_out_q <= chosen_q;
			full_out_q   <= full_q;
		end
	end

	assign stat.scan_done  = !rd_en && !rd_vld_s1;
	assign stat.have_first = have_first_q;
	assign stat.total_zero = (total_q == '0);
	assign stat.div_done   = div_done;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign found       = found_out_q;
	assign chosen_move = chosen_out_q;
	assign table_full  = full_out_q;

endmodule

[src/weighted_multimap_picker.sv]
// ----------------------------------------------------------------------------
// weighted_multimap_picker: weighted move table with roulette wheel lookup
// Appends (key, move, weight) entries; a lookup picks a matching move at
// random in proportion to its weight.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    operation position_key move_word move_weight
//                                random_value
//  out      out_valid/out_ready  found chosen_move table_full
//
//  An insert goes from acceptance straight to the finish state. A lookup makes
//  two passes over the entries in use (at most 64) and, between them, reduces the
//  31-bit draw modulo the weight sum, one remainder bit per cycle.
//  A lookup with no match or a zero weight sum skips the remainder and pick pass.
//  Reset clears the fill count; memory contents need no clearing pass.
//  A new transaction is taken while the previous result waits on out_ready.
// ----------------------------------------------------------------------------
module weighted_multimap_picker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            operation,
	input  logic [wmp_pkg::KEY_BITS-1:0]    position_key,
	input  logic [wmp_pkg::MOVE_BITS-1:0]   move_word,
	input  logic [wmp_pkg::WEIGHT_BITS-1:0] move_weight,
	input  logic [wmp_pkg::RAND_BITS-1:0]   random_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	output logic [wmp_pkg::MOVE_BITS-1:0]   chosen_move,
	output logic                            table_full
);
	import wmp_pkg::*;

	wmp_cmd_t  cmd;
	wmp_stat_t stat;

	// sequencer
	wmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (operation),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table, scan and remainder datapath
	wmp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.operation    (operation),
		.position_key (position_key),
		.move_word    (move_word),
		.move_weight  (move_weight),
		.random_value (random_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.chosen_move  (chosen_move),
		.table_full   (table_full)
	);

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the weighted multimap picker
// Fills the move table, then drives lookups and inserts over the valid/ready
// channels with random idle and stall bursts. Every result is checked against
// a local roulette-wheel predictor that keeps its own copy of the table.
// ----------------------------------------------------------------------------
module tb_top;
	import wmp_pkg::*;

	localparam int CLK_PERIOD      = 8;
	localparam int RESET_CYCLES    = 7;
	localparam int RANDOM_ITEMS    = 1980;
	localparam int TAIL_ITEMS      = 150;
	localparam int DRAIN_CYCLES    = 400;
	localparam int WATCHDOG_CYCLES = 1_500_000;
	localparam int KEY_POOL        = 8;

	typedef struct packed {
		logic                   op;
		logic [KEY_BITS-1:0]    key;
		logic [MOVE_BITS-1:0]   move;
		logic [WEIGHT_BITS-1:0] weight;
		logic [RAND_BITS-1:0]   draw;
	} wheel_item_t;

	typedef struct packed {
		logic                 found;
		logic [MOVE_BITS-1:0] move;
		logic                 full;
	} pick_result_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   in_valid     = 1'b0;
	logic                   in_ready;
	logic                   operation    = OP_INSERT;
	logic [KEY_BITS-1:0]    position_key = '0;
	logic [MOVE_BITS-1:0]   move_word    = '0;
	logic [WEIGHT_BITS-1:0] move_weight  = '0;
	logic [RAND_BITS-1:0]   random_value = '0;
	logic                   out_valid;
	logic                   out_ready    = 1'b0;
	logic                   found;
	logic [MOVE_BITS-1:0]   chosen_move;
	logic                   table_full;

	// move table as the predictor sees it
	logic [KEY_BITS-1:0]    tbl_key    [TABLE_ENTRIES];
	logic [MOVE_BITS-1:0]   tbl_move   [TABLE_ENTRIES];
	logic [WEIGHT_BITS-1:0] tbl_weight [TABLE_ENTRIES];
	int                     tbl_fill = 0;

	wheel_item_t  wheel_items[$];
	pick_result_t picks_due[$];
	int           queued_inserts = 0;
	int           n_total        = 0;
	int           items_sent     = 0;
	int           gap_left       = 0;
	int           stall_left     = 0;
	int           mismatches     = 0;
	logic         calm_tail;

	assign calm_tail = (items_sent + TAIL_ITEMS >= n_total);

	weighted_multimap_picker i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.position_key (position_key),
		.move_word    (move_word),
		.move_weight  (move_weight),
		.random_value (random_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.chosen_move  (chosen_move),
		.table_full   (table_full)
	);

	// clock
	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// reset, released once
	initial begin
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	// apply one transaction to the table copy and return the result it causes
	function automatic pick_result_t roulette_outcome(input wheel_item_t it);
		pick_result_t r;
		logic [63:0]  total;
		logic [63:0]  running;
		logic [63:0]  draw;
		bit           first_seen;
		r          = '0;
		total      = '0;
		running    = '0;
		draw       = '0;
		first_seen = 1'b0;
		if (it.op == OP_INSERT) begin
			if (tbl_fill < TABLE_ENTRIES) begin
				tbl_key[tbl_fill]    = it.key;
				tbl_move[tbl_fill]   = it.move;
				tbl_weight[tbl_fill] = it.weight;
				tbl_fill++;
			end else begin
				r.full = 1'b1;
			end
		end else begin
			// sum matching weights, remember the first matching move
			for (int i = 0; i < tbl_fill; i++) begin
				if (tbl_key[i] == it.key) begin
					if (!first_seen) begin
						first_seen = 1'b1;
						r.move     = tbl_move[i];
					end
					total += 64'(tbl_weight[i]);
				end
			end
			if (first_seen) begin
				r.found = 1'b1;
				// zero sum keeps the first match
				if (total != 0) begin
					draw = 64'(it.draw) % total;
					for (int i = 0; i < tbl_fill; i++) begin
						if (tbl_key[i] == it.key) begin
							running += 64'(tbl_weight[i]);
							if (draw < running) begin
								r.move = tbl_move[i];
								break;
							end
						end
					end
				end
			end
		end
		return r;
	endfunction

	task automatic push_insert(input logic [KEY_BITS-1:0] k, input logic [MOVE_BITS-1:0] m,
			input logic [WEIGHT_BITS-1:0] w);
		wheel_item_t it;
		it        = '0;
		it.op     = OP_INSERT;
		it.key    = k;
		it.move   = m;
		it.weight = w;
		it.draw   = RAND_BITS'($urandom);
		wheel_items = {wheel_items, it};
		queued_inserts++;
	endtask

	task automatic push_lookup(input logic [KEY_BITS-1:0] k, input logic [RAND_BITS-1:0] d);
		wheel_item_t it;
		it        = '0;
		it.op     = OP_LOOKUP;
		it.key    = k;
		it.move   = MOVE_BITS'($urandom);
		it.weight = WEIGHT_BITS'($urandom);
		it.draw   = d;
		wheel_items = {wheel_items, it};
	endtask

	// input driver: present queued transactions, predict each one on acceptance
	always @(posedge clk or negedge arst_n) begin : drive_proc
		wheel_item_t nxt;
		if (!arst_n) begin
			in_valid     <= 1'b0;
			operation    <= OP_INSERT;
			position_key <= '0;
			move_word    <= '0;
			move_weight  <= '0;
			random_value <= '0;
			gap_left     <= 0;
			items_sent   <= 0;
		end else begin
			if (in_valid && in_ready) begin
				nxt = {operation, position_key, move_word, move_weight, random_value};
				picks_due = {picks_due, roulette_outcome(nxt)};
				items_sent <= items_sent + 1;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (wheel_items.size() == 0) begin
					in_valid <= 1'b0;
				end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
					// idle burst
					gap_left <= $urandom_range(0, 4);
					in_valid <= 1'b0;
				end else begin
					nxt          = wheel_items.pop_front();
					operation    <= nxt.op;
					position_key <= nxt.key;
					move_word    <= nxt.move;
					move_weight  <= nxt.weight;
					random_value <= nxt.draw;
					in_valid     <= 1'b1;
				end
			end
		end
	end

	// result monitor: compare against the oldest prediction, stall in bursts
	always @(posedge clk or negedge arst_n) begin : check_proc
		pick_result_t want;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (picks_due.size() == 0) begin
					$error("unexpected result: found=%0b chosen_move=%h table_full=%0b",
						found, chosen_move, table_full);
					mismatches++;
				end else begin
					want = picks_due.pop_front();
					if (found !== want.found) begin
						$error("found: expected %0b, got %0b", want.found, found);
						mismatches++;
					end
					if (chosen_move !== want.move) begin
						$error("chosen_move: expected %h, got %h", want.move, chosen_move);
						mismatches++;
					end
					if (table_full !== want.full) begin
						$error("table_full: expected %0b, got %0b", want.full, table_full);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready  <= 1'b0;
			end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
				stall_left <= $urandom_range(0, 4);
				out_ready  <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// stimulus and end of run
	initial begin : run_ctrl
		logic [KEY_BITS-1:0]    key_pool [KEY_POOL];
		logic [KEY_BITS-1:0]    k;
		logic [WEIGHT_BITS-1:0] w;
		logic [RAND_BITS-1:0]   d;
		int                     slot;

		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = {16{4'hA}};
		for (int i = 3; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

		// empty table: no match
		push_lookup('0, '0);
		push_lookup('1, '1);
		// only zero weights: first match wins
		push_insert('0, '0, '0);
		push_insert('0, '1, '0);
		push_lookup('0, '1);
		// walk boundaries across three entries of one key
		push_insert('1, '1, '1);
		push_insert('1, 24'h123456, 16'd1);
		push_insert('1, '0, '1);
		push_lookup('1, '0);
		push_lookup('1, 31'd65534);
		push_lookup('1, 31'd65535);
		push_lookup('1, 31'd65536);
		push_lookup('1, '1);
		push_lookup(64'd1, RAND_BITS'($urandom));
		// zero-weight entry ahead of a weighted one is skipped by the walk
		push_insert(key_pool[2], 24'h555555, '0);
		push_insert(key_pool[2], 24'hAAAAAA, 16'd3);
		push_lookup(key_pool[2], '0);
		push_lookup(key_pool[2], 31'd2);
		push_lookup(key_pool[2], 31'd3);

		// random mix: fill the table, then mostly lookups and a few dropped inserts
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 99) < ((queued_inserts < TABLE_ENTRIES) ? 60 : 8)) begin
				slot = $urandom_range(0, KEY_POOL - 1);
				case ($urandom_range(0, 9))
					0, 1:       w = '0;
					2, 3:       w = '1;
					4, 5, 6, 7: w = WEIGHT_BITS'($urandom_range(1, 15));
					default:    w = WEIGHT_BITS'($urandom);
				endcase
				// keep the all-zero key a zero-sum group
				if (slot == 0) w = '0;
				push_insert(key_pool[slot], MOVE_BITS'($urandom), w);
			end else begin
				if ($urandom_range(0, 99) < 85)
					k = key_pool[$urandom_range(0, KEY_POOL - 1)];
				else
					k = {$urandom, $urandom};
				case ($urandom_range(0, 9))
					0:       d = '0;
					1:       d = '1;
					default: d = RAND_BITS'($urandom);
				endcase
				push_lookup(k, d);
			end
		end
		n_total = wheel_items.size();

		// wait until every transaction is in and every result is out
		while (items_sent < n_total || picks_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("weighted_multimap_picker test passed");
		else
			$display("weighted_multimap_picker test failed");
		$finish;
	end

	// watchdog
	initial begin
		#(CLK_PERIOD * WATCHDOG_CYCLES);
		$display("weighted_multimap_picker test failed");
		$finish;
	end

endmodule
